### hw/rtl/qrm_pkg.sv
// Shared constants for the rotation matrix to quaternion pipeline.
// No dependencies; imported by every module of the block.
package qrm_pkg;

    // Default number of fraction bits of matrix and quaternion words
    localparam int FRACTION_BITS_DEF = 16;
    // Normalized magnitudes carry their largest top bit at this position
    localparam int NORM_TOP = 29;
    localparam int NORM_W   = NORM_TOP + 1;

endpackage

### hw/rtl/rotation_matrix_to_quaternion.sv
// Top level of the rotation matrix to unit quaternion pipeline.
// Depends on qrm_pkg, qrm_front, qrm_sqrt and qrm_div.
//
// Takes one 3x3 rotation matrix per request (Q1.FRACTION_BITS, signed) and returns
// the normalized quaternion; a new matrix can enter every cycle while no result is
// held at the output. It runs through 5 front stages, NORM_W+1 square-root stages (31),
// FRACTION_BITS+1 divider stages and one output register. The pipeline freezes
// as a whole while a finished result waits on m_axis_tready, and accepts a
// request whenever the output register is empty or being taken.
// A matrix whose leading square-root argument is not positive yields the identity
// with the degenerate flag set.
module rotation_matrix_to_quaternion #(
    parameter int FRACTION_BITS = qrm_pkg::FRACTION_BITS_DEF
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             s_axis_tvalid,
    output logic                                             s_axis_tready,
    // m_00, m_01, m_02, m_10, m_11, m_12, m_20, m_21, m_22, then zero fill
    input  logic [((9*(FRACTION_BITS+2)+7)/8)*8-1:0]         s_axis_tdata,
    output logic                                             m_axis_tvalid,
    input  logic                                             m_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, then zero fill
    output logic [((4*(FRACTION_BITS+2)+7)/8)*8-1:0]         m_axis_tdata,
    // degenerate
    output logic                                             m_axis_tuser
);
    import qrm_pkg::*;

    localparam int W     = FRACTION_BITS + 2;
    localparam int NW    = NORM_W;
    localparam int SW    = 2 * NW + 2;
    localparam int RW    = SW / 2;
    localparam int QB    = FRACTION_BITS + 1;
    localparam int PW1   = 4 * NW + 5;
    localparam int PW2   = 5;
    localparam int OUT_W = ((4 * W + 7) / 8) * 8;
    localparam logic [QB-1:0] ONE_QB = QB'(1) << FRACTION_BITS;
    localparam logic [W-1:0]  ONE_W  = W'(1) << FRACTION_BITS;

    logic en;
    logic out_vld_reg;

    // whole pipe advances unless a result is held at the output
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    logic            f_vld;
    logic [SW-1:0]   f_sum;
    logic [PW1-1:0]  f_pay;

    qrm_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_axis_tvalid),
        .in_data (s_axis_tdata[9*W-1:0]),
        .out_vld (f_vld),
        .out_sum (f_sum),
        .out_pay (f_pay)
    );

    logic            r_vld;
    logic [RW-1:0]   r_root;
    logic [PW1-1:0]  r_pay;

    qrm_sqrt #(.SW(SW), .PW(PW1)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (f_vld),
        .in_rad   (f_sum),
        .in_pay   (f_pay),
        .out_vld  (r_vld),
        .out_root (r_root),
        .out_pay  (r_pay)
    );

    logic             d_vld;
    logic [4*QB-1:0]  d_quot;
    logic [PW2-1:0]   d_pay;

    qrm_div #(.FRACTION_BITS(FRACTION_BITS), .RW(RW), .PW(PW2)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (r_vld),
        .in_mag   (r_pay[4*NW-1:0]),
        .in_root  (r_root),
        .in_pay   (r_pay[PW1-1:4*NW]),
        .out_vld  (d_vld),
        .out_quot (d_quot),
        .out_pay  (d_pay)
    );

    // saturate, restore sign, substitute identity for degenerate requests
    logic [3:0]    d_neg;
    logic          d_deg;
    logic [QB-1:0] sat;
    logic [W-1:0]  comp_next [4];

    assign d_neg = d_pay[3:0];
    assign d_deg = d_pay[4];

    always_comb
    begin
        sat = '0;
        for (int c = 0; c < 4; c++)
        begin
            sat          = (d_quot[c*QB +: QB] > ONE_QB) ? ONE_QB : d_quot[c*QB +: QB];
            comp_next[c] = d_neg[c] ? W'(-W'(sat)) : W'(sat);
        end
        if (d_deg)
        begin
            comp_next[0] = '0;
            comp_next[1] = '0;
            comp_next[2] = '0;
            comp_next[3] = ONE_W;
        end
    end

    logic [W-1:0] comp_reg [4];
    logic         deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= d_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            comp_reg <= comp_next;
            deg_reg  <= d_deg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = OUT_W'({comp_reg[3], comp_reg[2], comp_reg[1], comp_reg[0]});
    assign m_axis_tuser  = deg_reg;

endmodule

### hw/rtl/qrm_front.sv
// Front end: unnormalized quaternion, magnitudes, common rescale, sum of squares.
// Depends on qrm_pkg. Five register stages, all advanced by en.
module qrm_front #(
    parameter int FRACTION_BITS = qrm_pkg::FRACTION_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     en,
    input  logic                                     in_vld,
    input  logic [9*(FRACTION_BITS+2)-1:0]           in_data,
    output logic                                     out_vld,
    output logic [2*qrm_pkg::NORM_W+1:0]             out_sum,
    // {deg, neg[3:0], mag w, mag z, mag y, mag x}
    output logic [4*qrm_pkg::NORM_W+4:0]             out_pay
);
    import qrm_pkg::*;

    localparam int W   = FRACTION_BITS + 2;
    localparam int QW  = W + 2;
    localparam int MW  = W + 1;
    localparam int NW  = NORM_W;
    localparam int SW  = 2 * NW + 2;
    localparam int PBW = $clog2(MW + 1);
    localparam logic [QW-1:0] ONE_Q = QW'(1) << FRACTION_BITS;

    // ---- stage 1: components from the matrix ----
    logic signed [QW-1:0] e [9];
    logic signed [QW-1:0] tr, arg;
    logic signed [QW-1:0] q_next [4];
    logic                 deg1_next;
    logic [1:0]           lead;

    always_comb
    begin
        for (int n = 0; n < 9; n++)
        begin
            e[n] = $signed({{2{in_data[n*W+W-1]}}, in_data[n*W +: W]});
        end
        tr        = e[0] + e[4] + e[8];
        arg       = '0;
        deg1_next = 1'b0;
        lead      = 2'd0;
        if (e[4] > e[0])
        begin
            lead = 2'd1;
        end
        if (e[8] > ((lead == 2'd1) ? e[4] : e[0]))
        begin
            lead = 2'd2;
        end
        if (tr > 0)
        begin
            q_next[3] = tr + $signed(ONE_Q);
            q_next[0] = e[5] - e[7];
            q_next[1] = e[6] - e[2];
            q_next[2] = e[1] - e[3];
        end
        else
        begin
            case (lead)
                2'd0:
                begin
                    arg       = e[0] - (e[4] + e[8]) + $signed(ONE_Q);
                    q_next[0] = arg;
                    q_next[3] = e[5] - e[7];
                    q_next[1] = e[1] + e[3];
                    q_next[2] = e[2] + e[6];
                end
                2'd1:
                begin
                    arg       = e[4] - (e[8] + e[0]) + $signed(ONE_Q);
                    q_next[1] = arg;
                    q_next[3] = e[6] - e[2];
                    q_next[2] = e[5] + e[7];
                    q_next[0] = e[3] + e[1];
                end
                default:
                begin
                    arg       = e[8] - (e[0] + e[4]) + $signed(ONE_Q);
                    q_next[2] = arg;
                    q_next[3] = e[1] - e[3];
                    q_next[0] = e[6] + e[2];
                    q_next[1] = e[7] + e[5];
                end
            endcase
            deg1_next = (arg <= 0);
        end
    end

    logic signed [QW-1:0] q_reg [4];
    logic                 deg1_reg, vld1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg    <= q_next;
            deg1_reg <= deg1_next;
        end
    end

    // ---- stage 2: sign and magnitude ----
    logic [MW-1:0] mag_next [4];
    logic [3:0]    neg_next;
    logic [QW-1:0] absq;
    logic [MW-1:0] orv_next;

    always_comb
    begin
        orv_next = '0;
        absq     = '0;
        for (int c = 0; c < 4; c++)
        begin
            neg_next[c] = q_reg[c][QW-1];
            absq        = neg_next[c] ? QW'(-q_reg[c]) : QW'(q_reg[c]);
            mag_next[c] = absq[MW-1:0];
            orv_next    = orv_next | mag_next[c];
        end
    end

    logic [MW-1:0] mag2_reg [4];
    logic [MW-1:0] orv_reg;
    logic [3:0]    neg2_reg;
    logic          deg2_reg, vld2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag2_reg <= mag_next;
            orv_reg  <= orv_next;
            neg2_reg <= neg_next;
            deg2_reg <= deg1_reg;
        end
    end

    // ---- stage 3: common rescale so the largest top bit lands at NORM_TOP ----
    logic [PBW-1:0]   top;
    logic [MW+NW-1:0] wide;
    logic [NW-1:0]    nmag_next [4];

    always_comb
    begin
        top  = '0;
        wide = '0;
        for (int k = 0; k < MW; k++)
        begin
            if (orv_reg[k])
            begin
                top = PBW'(k);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            wide         = {mag2_reg[c], {NW{1'b0}}} >> (top + PBW'(1));
            nmag_next[c] = wide[NW-1:0];
        end
    end

    logic [NW-1:0] nmag3_reg [4];
    logic [3:0]    neg3_reg;
    logic          deg3_reg, vld3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
        end
        else if (en)
        begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag3_reg <= nmag_next;
            neg3_reg  <= neg2_reg;
            deg3_reg  <= deg2_reg | (orv_reg == '0);
        end
    end

    // ---- stage 4: squares ----
    logic [2*NW-1:0] sq4_reg [4];
    logic [NW-1:0]   nmag4_reg [4];
    logic [3:0]      neg4_reg;
    logic            deg4_reg, vld4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 4; c++)
            begin
                sq4_reg[c] <= nmag3_reg[c] * nmag3_reg[c];
            end
            nmag4_reg <= nmag3_reg;
            neg4_reg  <= neg3_reg;
            deg4_reg  <= deg3_reg;
        end
    end

    // ---- stage 5: sum of squares ----
    logic [SW-1:0] sum5_reg;
    logic [NW-1:0] nmag5_reg [4];
    logic [3:0]    neg5_reg;
    logic          deg5_reg, vld5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld5_reg <= 1'b0;
        end
        else if (en)
        begin
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum5_reg  <= SW'(sq4_reg[0]) + SW'(sq4_reg[1]) + SW'(sq4_reg[2])
                       + SW'(sq4_reg[3]);
            nmag5_reg <= nmag4_reg;
            neg5_reg  <= neg4_reg;
            deg5_reg  <= deg4_reg;
        end
    end

    assign out_vld = vld5_reg;
    assign out_sum = sum5_reg;
    assign out_pay = {deg5_reg, neg5_reg, nmag5_reg[3], nmag5_reg[2], nmag5_reg[1],
                      nmag5_reg[0]};

endmodule

### hw/rtl/qrm_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a side payload.
// Depends on qrm_pkg for the default radicand width.
module qrm_sqrt #(
    parameter int SW = 2 * qrm_pkg::NORM_W + 2,
    parameter int PW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [SW-1:0]     in_rad,
    input  logic [PW-1:0]     in_pay,
    output logic              out_vld,
    output logic [SW/2-1:0]   out_root,
    output logic [PW-1:0]     out_pay
);
    import qrm_pkg::*;

    localparam int RW = SW / 2;

    logic [SW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [PW-1:0] pay_reg  [RW];
    logic [RW-1:0] vld_reg;

    genvar i;
    generate
        for (i = 0; i < RW; i++)
        begin : g_stage
            localparam int B = RW - 1 - i;
            logic [SW-1:0] rem_in, trial;
            logic [RW-1:0] root_in;
            logic [PW-1:0] pay_in;
            logic          vld_in;

            // stage input: port for the first stage, previous register otherwise
            if (i == 0)
            begin : g_first
                assign rem_in  = in_rad;
                assign root_in = '0;
                assign pay_in  = in_pay;
                assign vld_in  = in_vld;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[i-1];
                assign root_in = root_reg[i-1];
                assign pay_in  = pay_reg[i-1];
                assign vld_in  = vld_reg[i-1];
            end

            // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
            assign trial = (SW'(root_in) << (B + 1)) | (SW'(1) << (2 * B));

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (rem_in >= trial)
                    begin
                        rem_reg[i]  <= rem_in - trial;
                        root_reg[i] <= root_in | (RW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[i]  <= rem_in;
                        root_reg[i] <= root_in;
                    end
                    pay_reg[i] <= pay_in;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[RW-1];
    assign out_root = root_reg[RW-1];
    assign out_pay  = pay_reg[RW-1];

endmodule

### hw/rtl/qrm_div.sv
// Four-lane pipelined restoring divider: rounded |c| * 2^F / root, one bit per stage.
// Depends on qrm_pkg.
module qrm_div #(
    parameter int FRACTION_BITS = qrm_pkg::FRACTION_BITS_DEF,
    parameter int RW            = qrm_pkg::NORM_W + 1,
    parameter int PW            = 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic [4*qrm_pkg::NORM_W-1:0]         in_mag,
    input  logic [RW-1:0]                        in_root,
    input  logic [PW-1:0]                        in_pay,
    output logic                                 out_vld,
    output logic [4*(FRACTION_BITS+1)-1:0]       out_quot,
    output logic [PW-1:0]                        out_pay
);
    import qrm_pkg::*;

    localparam int NW = NORM_W;
    localparam int QB = FRACTION_BITS + 1;
    localparam int DW = NW + FRACTION_BITS + 1;
    localparam int NS = QB;

    logic [DW-1:0] rem_reg  [NS][4];
    logic [QB-1:0] quot_reg [NS][4];
    logic [RW-1:0] root_reg [NS];
    logic [PW-1:0] pay_reg  [NS];
    logic [NS-1:0] vld_reg;

    genvar i, c;
    generate
        for (i = 0; i < NS; i++)
        begin : g_stage
            localparam int B = FRACTION_BITS - i;
            logic [DW-1:0] rem_in  [4];
            logic [QB-1:0] quot_in [4];
            logic [RW-1:0] root_in;
            logic [PW-1:0] pay_in;
            logic          vld_in;
            logic [DW-1:0] dsh;

            // first stage forms the numerator with half-divisor rounding
            if (i == 0)
            begin : g_first
                for (c = 0; c < 4; c++)
                begin : g_lane
                    assign rem_in[c]  = (DW'(in_mag[c*NW +: NW]) << FRACTION_BITS)
                                      + DW'(in_root >> 1);
                    assign quot_in[c] = '0;
                end
                assign root_in = in_root;
                assign pay_in  = in_pay;
                assign vld_in  = in_vld;
            end
            else
            begin : g_next
                for (c = 0; c < 4; c++)
                begin : g_lane
                    assign rem_in[c]  = rem_reg[i-1][c];
                    assign quot_in[c] = quot_reg[i-1][c];
                end
                assign root_in = root_reg[i-1];
                assign pay_in  = pay_reg[i-1];
                assign vld_in  = vld_reg[i-1];
            end

            assign dsh = DW'(root_in) << B;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int l = 0; l < 4; l++)
                    begin
                        if (rem_in[l] >= dsh)
                        begin
                            rem_reg[i][l]  <= rem_in[l] - dsh;
                            quot_reg[i][l] <= quot_in[l] | (QB'(1) << B);
                        end
                        else
                        begin
                            rem_reg[i][l]  <= rem_in[l];
                            quot_reg[i][l] <= quot_in[l];
                        end
                    end
                    root_reg[i] <= root_in;
                    pay_reg[i]  <= pay_in;
                end
            end
        end

        for (c = 0; c < 4; c++)
        begin : g_out
            assign out_quot[c*QB +: QB] = quot_reg[NS-1][c];
        end
    endgenerate

    assign out_vld = vld_reg[NS-1];
    assign out_pay = pay_reg[NS-1];

endmodule

### tb/tb_top.sv
// Testbench for rotation_matrix_to_quaternion: directed and random matrices, with
// the expected quaternions computed here and compared per field as results arrive.
// Depends on qrm_pkg and the rotation_matrix_to_quaternion RTL.
module tb_top;

    localparam int FB     = qrm_pkg::FRACTION_BITS_DEF;
    localparam int WB     = FB + 2;
    localparam int IN_W   = ((9*WB+7)/8)*8;
    localparam int OUT_W  = ((4*WB+7)/8)*8;
    localparam longint UNIT = 64'sd1 << FB;
    localparam int LATENCY = 60;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [WB-1:0] word_t;
    typedef struct packed {
        word_t w, z, y, x;
        logic  degen;
    } quat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic m_axis_tuser;

    quat_t  quat_expected[$];
    int     error_count = 0;
    longint cycle_count = 0;
    bit     stall_enable = 1'b1;

    rotation_matrix_to_quaternion u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Expected unit quaternion for one matrix
    function automatic quat_t quat_from_matrix(word_t m[3][3]);
        longint q[4];
        longint unsigned mag[4], maxv, total, root, v;
        bit neg[4];
        longint tr, a;
        int i, j, k, p;
        quat_t res;
        res = '{x: '0, y: '0, z: '0, w: word_t'(UNIT), degen: 1'b1};
        tr = longint'(m[0][0]) + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            q[3] = tr + UNIT;
            q[0] = longint'(m[1][2]) - m[2][1];
            q[1] = longint'(m[2][0]) - m[0][2];
            q[2] = longint'(m[0][1]) - m[1][0];
        end
        else
        begin
            i = 0;
            if (m[1][1] > m[0][0]) i = 1;
            if (m[2][2] > m[i][i]) i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            a = longint'(m[i][i]) - (longint'(m[j][j]) + m[k][k]) + UNIT;
            if (a <= 0)
                return res;
            q[i] = a;
            q[3] = longint'(m[j][k]) - m[k][j];
            q[j] = longint'(m[i][j]) + m[j][i];
            q[k] = longint'(m[i][k]) + m[k][i];
        end
        maxv = 0;
        for (int c = 0; c < 4; c++)
        begin
            neg[c] = q[c] < 0;
            mag[c] = neg[c] ? -q[c] : q[c];
            if (mag[c] > maxv) maxv = mag[c];
        end
        if (maxv == 0)
            return res;
        p = 0;
        while (p < 63 && (maxv >> (p + 1)) != 0)
            p++;
        total = 0;
        for (int c = 0; c < 4; c++)
        begin
            if (p > qrm_pkg::NORM_TOP)
                mag[c] >>= (p - qrm_pkg::NORM_TOP);
            else
                mag[c] <<= (qrm_pkg::NORM_TOP - p);
            total += mag[c] * mag[c];
        end
        root = int_sqrt(total);
        if (root == 0)
            return res;
        for (int c = 0; c < 4; c++)
        begin
            v = ((mag[c] << FB) + (root >> 1)) / root;
            if (v > UNIT) v = UNIT;
            q[c] = neg[c] ? -longint'(v) : longint'(v);
        end
        res = '{x: word_t'(q[0]), y: word_t'(q[1]), z: word_t'(q[2]),
                w: word_t'(q[3]), degen: 1'b0};
        return res;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", field, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Receiver stall pattern: bursts of stall, or none
    always @(posedge clk)
    begin
        if (!stall_enable)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ((cycle_count % 97) < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end

    // Result checker
    always @(posedge clk)
    begin
        quat_t want;
        word_t gx, gy, gz, gw;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            gx = m_axis_tdata[0*WB +: WB];
            gy = m_axis_tdata[1*WB +: WB];
            gz = m_axis_tdata[2*WB +: WB];
            gw = m_axis_tdata[3*WB +: WB];
            if (quat_expected.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                want = quat_expected.pop_front();
                if (gx !== want.x) report_mismatch("quat_x", gx, want.x);
                if (gy !== want.y) report_mismatch("quat_y", gy, want.y);
                if (gz !== want.z) report_mismatch("quat_z", gz, want.z);
                if (gw !== want.w) report_mismatch("quat_w", gw, want.w);
                if (m_axis_tuser !== want.degen)
                    report_mismatch("degenerate", m_axis_tuser, want.degen);
            end
        end
    end

    // Send one matrix and wait for acceptance
    task automatic send_matrix(word_t m[3][3]);
        logic [IN_W-1:0] d;
        d = '0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                d[(r*3+c)*WB +: WB] = m[r][c];
        s_axis_tdata  <= d;
        s_axis_tvalid <= 1'b1;
        quat_expected.push_back(quat_from_matrix(m));
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // A zero-length gap leaves tvalid to the next send
    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (quat_expected.size() != 0)
            @(posedge clk);
    endtask

    function automatic word_t rand_word();
        return word_t'($urandom_range(0, (1 << WB) - 1));
    endfunction

    function automatic word_t rand_in_range();
        return word_t'(int'($urandom_range(0, 2*UNIT)) - int'(UNIT));
    endfunction

    // Rotation about a random axis by a random angle (axis-angle form), with up to 4 LSBs of noise
    task automatic make_rotation(output word_t m[3][3]);
        real ax, ay, az, n, ang, c, s, t, r[3][3];
        ax = $urandom_range(0, 2000) - 1000.0;
        ay = $urandom_range(0, 2000) - 1000.0;
        az = $urandom_range(0, 2000) - 1000.0;
        n = $sqrt(ax*ax + ay*ay + az*az);
        if (n == 0.0) begin ax = 1.0; n = 1.0; end
        ax /= n; ay /= n; az /= n;
        ang = $urandom_range(0, 62832) / 10000.0;
        c = $cos(ang); s = $sin(ang); t = 1.0 - c;
        r[0][0] = t*ax*ax + c;    r[0][1] = t*ax*ay - s*az; r[0][2] = t*ax*az + s*ay;
        r[1][0] = t*ax*ay + s*az; r[1][1] = t*ay*ay + c;    r[1][2] = t*ay*az - s*ax;
        r[2][0] = t*ax*az - s*ay; r[2][1] = t*ay*az + s*ax; r[2][2] = t*az*az + c;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = word_t'($rtoi(r[i][j] * UNIT + $urandom_range(0, 8) - 4.0));
    endtask

    // Directed: identity, axis flips, ties, degenerate, extremes
    task automatic test_directed();
        word_t m[3][3];
        int diag[3];
        for (int n = 0; n < 14; n++)
        begin
            foreach (m[i, j]) m[i][j] = '0;
            case (n)
                0: diag = '{1, 1, 1};
                1: diag = '{1, -1, -1};
                2: diag = '{-1, 1, -1};
                3: diag = '{-1, -1, 1};
                4: diag = '{0, 0, 0};
                5: diag = '{-1, -1, -1};
                default: diag = '{0, 0, 0};
            endcase
            for (int i = 0; i < 3; i++)
                m[i][i] = word_t'(diag[i] * UNIT);
            if (n == 6) foreach (m[i, j]) m[i][j] = {1'b1, {(WB-1){1'b0}}};
            if (n == 7) foreach (m[i, j]) m[i][j] = {1'b0, {(WB-1){1'b1}}};
            if (n == 8) foreach (m[i, j]) m[i][j] = word_t'(-UNIT);
            if (n == 9) foreach (m[i, j]) m[i][j] = word_t'(UNIT);
            if (n == 10) begin m[0][0] = word_t'(UNIT/2); m[1][1] = word_t'(UNIT/2);
                m[2][2] = word_t'(-UNIT); m[0][1] = 1; end
            if (n == 11) begin m[1][1] = word_t'(-UNIT/2); m[2][2] = word_t'(-UNIT/2);
                m[0][0] = word_t'(-UNIT/2); end
            if (n == 12) begin m[0][1] = word_t'(-UNIT); m[1][0] = word_t'(UNIT);
                m[2][2] = word_t'(UNIT); end
            if (n == 13) begin m[0][0] = word_t'(-UNIT); m[1][1] = word_t'(-UNIT);
                m[2][2] = word_t'(UNIT/4); m[1][2] = word_t'(UNIT/3); end
            send_matrix(m);
        end
        wait_drained();
    endtask

    // Random: mostly true rotations, some uniform in range, some raw bit patterns
    task automatic test_random(int count);
        word_t m[3][3];
        int burst;
        int sel;
        burst = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
            begin
                // hold off until the pipeline is empty
                wait_drained();
                stall_enable = 1'b0;
            end
            if (n == count * 3 / 4)
                stall_enable = 1'b1;
            if (burst == 0)
            begin
                idle_cycles($urandom_range(0, 6));
                burst = $urandom_range(1, 30);
            end
            burst--;
            sel = $urandom_range(0, 9);
            if (sel < 6)
                make_rotation(m);
            else if (sel < 8)
                foreach (m[i, j]) m[i][j] = rand_in_range();
            else
                foreach (m[i, j]) m[i][j] = rand_word();
            send_matrix(m);
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(740);
        repeat (LATENCY) @(posedge clk);
        if (error_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
